FILE: hw/rtl/sdaf_pkg.sv
// Shared constants and types for the signed decimal ASCII formatter.
`default_nettype none

package sdaf_pkg;

  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned DIGITS_W   = MAX_DIGITS * DIGIT_W;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned PROD_W     = 2 * VALUE_W;
  localparam int unsigned QUOT_SHIFT = 35;
  localparam int unsigned CODE_W     = 6;

  localparam logic [VALUE_W-1:0] RECIP_TEN  = 32'hCCCC_CCCD;
  localparam logic [CODE_W-1:0]  CODE_MINUS = 6'd45;
  localparam logic [CODE_W-1:0]  CODE_ZERO  = 6'd48;
  localparam logic [CNT_W-1:0]   LAST_CNT   = CNT_W'(MAX_DIGITS - 1);

  typedef struct packed {
    logic                neg;
    logic [CNT_W-1:0]    count;
    logic [DIGITS_W-1:0] digits;
  } sdaf_entry_t;

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_MUL  = 4'b0010,
    F_DIV  = 4'b0100,
    F_PUSH = 4'b1000
  } sdaf_front_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sdaf_front.sv
// Front end: takes a number, forms its magnitude and splits it into digits.
`default_nettype none

module sdaf_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [31:0]                 value,
  output logic                             busy,
  input  wire logic                        full,
  output logic                             push,
  output sdaf_pkg::sdaf_entry_t            entry
);

  sdaf_pkg::sdaf_front_state_t state, state_next;

  logic [sdaf_pkg::VALUE_W-1:0]  mag;
  logic [sdaf_pkg::PROD_W-1:0]   prod;
  logic                          neg;
  logic [sdaf_pkg::CNT_W-1:0]    cnt;
  logic [sdaf_pkg::DIGITS_W-1:0] digits;

  logic [sdaf_pkg::VALUE_W-1:0]  quot;
  logic [sdaf_pkg::VALUE_W-1:0]  quot_x10;
  logic [sdaf_pkg::VALUE_W-1:0]  diff;
  logic [sdaf_pkg::DIGIT_W-1:0]  digit;
  logic                          done_digit;

  assign quot       = {{sdaf_pkg::QUOT_SHIFT - sdaf_pkg::VALUE_W{1'b0}},
                       prod[sdaf_pkg::PROD_W-1:sdaf_pkg::QUOT_SHIFT]};
  assign quot_x10   = {quot[sdaf_pkg::VALUE_W-4:0], 3'b000} +
                      {quot[sdaf_pkg::VALUE_W-2:0], 1'b0};
  assign diff       = mag - quot_x10;
  assign digit      = diff[sdaf_pkg::DIGIT_W-1:0];
  assign done_digit = (quot == '0) || (cnt == sdaf_pkg::LAST_CNT);

  assign busy         = (state != sdaf_pkg::F_IDLE);
  assign push         = (state == sdaf_pkg::F_PUSH) && !full;
  assign entry.neg    = neg;
  assign entry.count  = cnt;
  assign entry.digits = digits;

  always_comb begin
    state_next = state;
    case (state)
      sdaf_pkg::F_IDLE: if (start) state_next = sdaf_pkg::F_MUL;
      sdaf_pkg::F_MUL:  state_next = sdaf_pkg::F_DIV;
      sdaf_pkg::F_DIV:  if (done_digit) state_next = sdaf_pkg::F_PUSH;
      sdaf_pkg::F_PUSH: if (!full) state_next = sdaf_pkg::F_IDLE;
      default:          state_next = sdaf_pkg::F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sdaf_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      sdaf_pkg::F_IDLE: begin
        neg <= value[31];
        mag <= value[31] ? (32'd0 - value) : value;
        cnt <= '0;
      end
      sdaf_pkg::F_MUL: begin
        prod <= mag * sdaf_pkg::RECIP_TEN;
      end
      sdaf_pkg::F_DIV: begin
        digits <= {digits[sdaf_pkg::DIGITS_W-sdaf_pkg::DIGIT_W-1:0], digit};
        cnt    <= cnt + 4'd1;
        mag    <= quot;
        prod   <= quot * sdaf_pkg::RECIP_TEN;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sdaf_queue.sv
// Two-entry queue of converted numbers between the front and back ends.
`default_nettype none

module sdaf_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire sdaf_pkg::sdaf_entry_t wr_entry,
  output logic                       full,
  input  wire logic                  pop,
  output sdaf_pkg::sdaf_entry_t      rd_entry,
  output logic                       empty
);

  sdaf_pkg::sdaf_entry_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign rd_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("transfer into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("transfer out of empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count out of range");
  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
      (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("queue count not decremented");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/sdaf_back.sv
// Back end: sends the sign and digits of each queued number, one per cycle.
`default_nettype none

module sdaf_back (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                empty,
  input  wire sdaf_pkg::sdaf_entry_t               rd_entry,
  output logic                                     pop,
  output logic                                     strobe,
  output logic [sdaf_pkg::CODE_W-1:0]              char_code,
  output logic                                     is_last
);

  logic                          active;
  logic                          neg_pend;
  logic [sdaf_pkg::CNT_W-1:0]    remain;
  logic [sdaf_pkg::DIGITS_W-1:0] shift;
  logic                          finishing;

  assign finishing = active && !neg_pend && (remain == 4'd1);
  assign pop       = !empty && (!active || finishing);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (finishing) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (active) begin
      if (neg_pend) begin
        char_code <= sdaf_pkg::CODE_MINUS;
        is_last   <= 1'b0;
      end else begin
        char_code <= sdaf_pkg::CODE_ZERO + {2'b00, shift[sdaf_pkg::DIGIT_W-1:0]};
        is_last   <= (remain == 4'd1);
      end
    end
    if (pop) begin
      neg_pend <= rd_entry.neg;
      remain   <= rd_entry.count;
      shift    <= rd_entry.digits;
    end else if (active) begin
      if (neg_pend) begin
        neg_pend <= 1'b0;
      end else begin
        shift  <= {{sdaf_pkg::DIGIT_W{1'b0}},
                   shift[sdaf_pkg::DIGITS_W-1:sdaf_pkg::DIGIT_W]};
        remain <= remain - 4'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/signed_decimal_ascii_formatter_core.sv
// Top level of the signed decimal ASCII formatter.
//
// Give a number with start while busy is low; its text comes out on char_code,
// one character per strobe cycle: '-' first for a negative number, then the
// decimal digits most significant first, with is_last on the final one. The
// receiver cannot stall, so take each character in its strobe cycle. The
// converter forms the magnitude, does the first reciprocal multiply, then
// yields one digit per cycle and hands the number off, waiting while the
// queue is full; the output side sends one character per cycle, the sign
// included. A two-entry queue sits between them, so the sustained rate is
// set by the slower side.
`default_nettype none

module signed_decimal_ascii_formatter_core (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic signed [31:0]             value,
  output logic                                busy,
  output logic                                strobe,
  output logic [sdaf_pkg::CODE_W-1:0]         char_code,
  output logic                                is_last
);

  sdaf_pkg::sdaf_entry_t wr_entry;
  sdaf_pkg::sdaf_entry_t rd_entry;
  logic push;
  logic full;
  logic pop;
  logic empty;

  sdaf_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .value (value),
    .busy  (busy),
    .full  (full),
    .push  (push),
    .entry (wr_entry)
  );

  sdaf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .rd_entry (rd_entry),
    .empty    (empty)
  );

  sdaf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .empty     (empty),
    .rd_entry  (rd_entry),
    .pop       (pop),
    .strobe    (strobe),
    .char_code (char_code),
    .is_last   (is_last)
  );

endmodule

`default_nettype wire

FILE: tb/tb_signed_decimal_ascii_formatter_core.sv
// Self-checking testbench for the signed decimal ASCII formatter core.
`timescale 1ns / 1ps
`default_nettype none

module tb_signed_decimal_ascii_formatter_core;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned N_DIRECTED = 20;
  localparam int unsigned N_PHASES = 4;
  localparam int unsigned ITEMS_PER_PHASE = 98;

  typedef struct {
    logic [sdaf_pkg::CODE_W-1:0] code;
    logic                        last;
  } char_t;

  logic                          clk;
  logic                          rst;
  logic                          start;
  logic signed [31:0]            value;
  logic                          busy;
  logic                          strobe;
  logic [sdaf_pkg::CODE_W-1:0]   char_code;
  logic                          is_last;

  char_t                   text_q[$];
  int unsigned             fail_cnt;
  int unsigned             quiet_cycles;

  logic [31:0] dir_value [N_DIRECTED] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    32'd12345, -32'sd987654321, 32'd999999999, 32'd1000000000, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAA,
    32'd1234567890, -32'sd1000000000
  };
  string dir_text [N_DIRECTED] = '{
    "0", "1", "-1", "9", "-9", "10", "-10", "", "100",
    "", "", "999999999", "1000000000", "2147483647",
    "-2147483648", "-2147483647", "", "",
    "", "-1000000000"
  };
  int unsigned phase_idle_pct [N_PHASES] = '{0, 68, 0, 7};

  signed_decimal_ascii_formatter_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .strobe    (strobe),
    .char_code (char_code),
    .is_last   (is_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void predict_text(input logic [31:0] num);
    logic [31:0] mag;
    logic [3:0]  digit_q[$];
    mag = num[31] ? (32'd0 - num) : num;
    if (num[31]) begin
      text_q.push_back('{sdaf_pkg::CODE_MINUS, 1'b0});
    end
    do begin
      digit_q.push_front(4'(mag % 32'd10));
      mag = mag / 32'd10;
    end while (mag != 32'd0);
    foreach (digit_q[i]) begin
      text_q.push_back('{sdaf_pkg::CODE_ZERO + sdaf_pkg::CODE_W'(digit_q[i]),
                         i == digit_q.size() - 1});
    end
  endfunction

  function automatic void push_literal_text(input string txt);
    for (int i = 0; i < txt.len(); i++) begin
      text_q.push_back('{sdaf_pkg::CODE_W'(txt[i]), i == txt.len() - 1});
    end
  endfunction

  function automatic logic [31:0] random_number();
    int unsigned pick;
    int unsigned n_dig;
    longint unsigned lo;
    longint unsigned hi;
    logic [31:0] mag;
    logic        neg;
    pick = $urandom_range(99);
    neg = 1'($urandom_range(1));
    if (pick < 15) begin
      return $urandom();
    end else if (pick < 20) begin
      case ($urandom_range(4))
        0: return 32'h0000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h8000_0000;
        3: return 32'hFFFF_FFFF;
        default: return 32'h8000_0001;
      endcase
    end
    n_dig = $urandom_range(10, 1);
    lo = (n_dig == 1) ? 0 : 1;
    hi = 9;
    for (int i = 1; i < n_dig; i++) begin
      lo = lo * 10;
      hi = hi * 10 + 9;
    end
    if (hi > 64'd2147483647) begin
      hi = neg ? 64'd2147483648 : 64'd2147483647;
    end
    mag = $urandom_range(32'(hi), 32'(lo));
    return neg ? (32'd0 - mag) : mag;
  endfunction

  task automatic send_number(input logic [31:0] num, input string txt,
                             input int unsigned idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      value <= $urandom();
      @(posedge clk);
    end
    start <= 1'b1;
    value <= num;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    if (txt.len() != 0) begin
      push_literal_text(txt);
    end else begin
      predict_text(num);
    end
  endtask

  task automatic wait_text_drained();
    while (text_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  always @(posedge clk) begin
    char_t exp_char;
    if (!rst && strobe) begin
      if (text_q.size() == 0) begin
        $error("char_code: no character expected, got %0d", char_code);
        fail_cnt++;
      end else begin
        exp_char = text_q.pop_front();
        if (char_code !== exp_char.code) begin
          $error("char_code: expected %0d, got %0d", exp_char.code, char_code);
          fail_cnt++;
        end
        if (is_last !== exp_char.last) begin
          $error("is_last: expected %0d, got %0d", exp_char.last, is_last);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("signed_decimal_ascii_formatter_core verification failed");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    value = '0;
    fail_cnt = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_number(dir_value[i], dir_text[i], 0);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      start <= 1'b0;
      wait_text_drained();
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_number(random_number(), "", phase_idle_pct[p]);
      end
    end

    start <= 1'b0;
    wait_text_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("signed_decimal_ascii_formatter_core verification clean");
    end else begin
      $display("signed_decimal_ascii_formatter_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
